@@ rtl/core/clle_pkg.sv @@
// Shared constants, types and helpers for the cursor linked list engine.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package clle_pkg;

	localparam int CELLS      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(CELLS + 1);
	localparam int IDX_W      = $clog2(CELLS);
	localparam int CMD_W      = 3;
	localparam int VAL_W      = 32;
	localparam int POS_W      = 5;
	localparam int STAT_W     = 3;
	localparam int SLOT_W     = 4;
	localparam int CMP_W      = (PTR_W > POS_W) ? PTR_W : POS_W;

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [STAT_W-1:0]     stat_t;

	localparam ptr_t NIL = PTR_W'(CELLS);

	localparam cmd_t CMD_INS_HEAD = 3'd0;
	localparam cmd_t CMD_INS_TAIL = 3'd1;
	localparam cmd_t CMD_INS_POS  = 3'd2;
	localparam cmd_t CMD_DEL_HEAD = 3'd3;
	localparam cmd_t CMD_DEL_VAL  = 3'd4;

	localparam stat_t ST_OK       = 3'd0;
	localparam stat_t ST_NOSPACE  = 3'd1;
	localparam stat_t ST_RANGE    = 3'd2;
	localparam stat_t ST_EMPTY    = 3'd3;
	localparam stat_t ST_NOTFOUND = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic alloc;
		logic init_walk;
		logic step;
		logic pop_head;
		logic unlink;
		logic free_cur;
		logic free_c;
		logic write_c;
		logic tail;
		logic link_c;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic free_nil;
		logic head_nil;
		logic cur_cell;
		logic cnt_lt_cells;
		logic cnt_lt_pos;
		logic data_match;
		ptr_t slot;
	} sts_t;

	function automatic data_t to_data(input logic [VAL_W-1:0] v);
		logic [63:0] w;
		w = {{(64 - VAL_W){v[VAL_W-1]}}, v};
		return w[DATA_WIDTH-1:0];
	endfunction

	function automatic logic is_cell(input ptr_t p);
		return p < NIL;
	endfunction

endpackage

@@ rtl/core/clle_if.sv @@
// Request and response channel interfaces of the cursor linked list engine.
// Depends on clle_pkg for field widths.
`timescale 1ns / 1ps

interface clle_req_if;
	logic                         valid;
	logic                         ready;
	logic [clle_pkg::CMD_W-1:0]   command;
	logic signed [clle_pkg::VAL_W-1:0] value;
	logic [clle_pkg::POS_W-1:0]   position;

	modport source(output valid, command, value, position, input ready);
	modport sink(input valid, command, value, position, output ready);
endinterface

interface clle_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [clle_pkg::STAT_W-1:0]   status;
	logic [clle_pkg::SLOT_W-1:0]   slot;

	modport source(output valid, status, slot, input ready);
	modport sink(input valid, status, slot, output ready);
endinterface

@@ rtl/core/cursor_linked_list_engine.sv @@
// Cursor linked list engine, top level: a singly linked list in a pool of
// cells with a free list threaded through the unused cells.
// Depends on clle_pkg, clle_if, clle_ctrl and clle_datapath.
//
// Channels: req carries command, value and position; rsp returns one
// request's status and slot. Both use valid/ready, a request moves on an edge
// where both are high.
// Sequence: delete head and codes without meaning go from S_START straight
// to S_DONE; no free cell or an empty list gives the same path.
// Insert head goes S_START, S_WALK, S_LINK, S_SETLINK, S_DONE. Insert tail,
// insert at position and delete value walk the list one link read per cycle
// on the single link-store read port before they reach S_DONE.
// Throughput: one request in flight; req.ready is high only while the
// controller is idle. The next request is taken while the previous response
// still waits in the output register.
// Stall: a response that is not taken holds; a finished request waits in
// the controller until the output register frees.
// Reset: the list is empty and the free list chains cell 0 through the last
// cell; the response register is empty. No clearing pass is needed.
`timescale 1ns / 1ps

module cursor_linked_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	clle_req_if.sink   req,
	clle_rsp_if.source rsp
);

	clle_pkg::ctl_t ctl;
	clle_pkg::sts_t sts;

	clle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_command (req.command),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_status  (rsp.status),
		.rsp_slot    (rsp.slot),
		.ctl         (ctl),
		.sts         (sts)
	);

	clle_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.req_value    (req.value),
		.req_position (req.position),
		.sts          (sts)
	);

endmodule

@@ rtl/core/clle_datapath.sv @@
// Datapath: cell data and link stores, list and free heads, walk registers.
// Driven by clle_ctrl through clle_pkg::ctl_t; reports through clle_pkg::sts_t.
`timescale 1ns / 1ps

module clle_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  clle_pkg::ctl_t             ctl,
	input  logic [clle_pkg::VAL_W-1:0] req_value,
	input  logic [clle_pkg::POS_W-1:0] req_position,
	output clle_pkg::sts_t             sts
);

	clle_pkg::ptr_t  cell_next_q [clle_pkg::CELLS];
	clle_pkg::data_t cell_data_q [clle_pkg::CELLS];

	clle_pkg::ptr_t  list_head_q;
	clle_pkg::ptr_t  free_head_q;
	clle_pkg::ptr_t  c_q;
	clle_pkg::ptr_t  prev_q;
	clle_pkg::ptr_t  cur_q;
	clle_pkg::ptr_t  cnt_q;
	clle_pkg::ptr_t  slot_q;
	clle_pkg::data_t val_q;
	logic [clle_pkg::POS_W-1:0] pos_q;

	clle_pkg::ptr_t  rd_addr;
	clle_pkg::ptr_t  rd_next;
	clle_pkg::data_t cur_data;
	logic            we;
	clle_pkg::ptr_t  waddr;
	clle_pkg::ptr_t  wdata;

	// single read port on the link store
	always_comb begin
		if (ctl.alloc) begin
			rd_addr = free_head_q;
		end else if (ctl.pop_head) begin
			rd_addr = list_head_q;
		end else begin
			rd_addr = cur_q;
		end
		rd_next = clle_pkg::is_cell(rd_addr) ? cell_next_q[rd_addr[clle_pkg::IDX_W-1:0]]
			: clle_pkg::NIL;
		cur_data = clle_pkg::is_cell(cur_q) ? cell_data_q[cur_q[clle_pkg::IDX_W-1:0]] : '0;
	end

	// single write port on the link store
	always_comb begin
		we    = 1'b0;
		waddr = c_q;
		wdata = free_head_q;
		if (ctl.pop_head) begin
			we    = 1'b1;
			waddr = list_head_q;
		end else if (ctl.unlink) begin
			we    = clle_pkg::is_cell(prev_q);
			waddr = prev_q;
			wdata = rd_next;
		end else if (ctl.free_cur) begin
			we    = 1'b1;
			waddr = cur_q;
		end else if (ctl.free_c) begin
			we    = 1'b1;
		end else if (ctl.write_c) begin
			we    = 1'b1;
			wdata = ctl.tail ? clle_pkg::NIL : cur_q;
		end else if (ctl.link_c) begin
			we    = clle_pkg::is_cell(prev_q);
			waddr = prev_q;
			wdata = c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < clle_pkg::CELLS; i++) begin
				cell_next_q[i] <= clle_pkg::PTR_W'(i + 1);
			end
			list_head_q <= clle_pkg::NIL;
			free_head_q <= '0;
		end else begin
			if (we) begin
				cell_next_q[waddr[clle_pkg::IDX_W-1:0]] <= wdata;
			end
			if (ctl.pop_head) begin
				list_head_q <= rd_next;
				free_head_q <= list_head_q;
			end
			if (ctl.alloc) begin
				free_head_q <= rd_next;
			end
			if (ctl.unlink && !clle_pkg::is_cell(prev_q)) begin
				list_head_q <= rd_next;
			end
			if (ctl.free_cur) begin
				free_head_q <= cur_q;
			end
			if (ctl.free_c) begin
				free_head_q <= c_q;
			end
			if (ctl.link_c && !clle_pkg::is_cell(prev_q)) begin
				list_head_q <= c_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			val_q  <= clle_pkg::to_data(req_value);
			pos_q  <= req_position;
			slot_q <= '0;
		end
		if (ctl.alloc) begin
			c_q <= free_head_q;
		end
		if (ctl.init_walk) begin
			prev_q <= clle_pkg::NIL;
			cur_q  <= list_head_q;
			cnt_q  <= '0;
		end
		if (ctl.step) begin
			prev_q <= cur_q;
			cur_q  <= rd_next;
			cnt_q  <= cnt_q + clle_pkg::PTR_W'(1);
		end
		if (ctl.pop_head) begin
			slot_q <= list_head_q;
		end
		if (ctl.write_c) begin
			slot_q <= c_q;
			cell_data_q[c_q[clle_pkg::IDX_W-1:0]] <= val_q;
		end
		if (ctl.free_cur) begin
			slot_q <= cur_q;
		end
	end

	always_comb begin
		sts.free_nil     = !clle_pkg::is_cell(free_head_q);
		sts.head_nil     = !clle_pkg::is_cell(list_head_q);
		sts.cur_cell     = clle_pkg::is_cell(cur_q);
		sts.cnt_lt_cells = cnt_q < clle_pkg::NIL;
		sts.cnt_lt_pos   = clle_pkg::CMP_W'(cnt_q) < clle_pkg::CMP_W'(pos_q);
		sts.data_match   = cur_data == val_q;
		sts.slot         = slot_q;
	end

endmodule

@@ rtl/core/clle_ctrl.sv @@
// Controller: command sequencing state machine and the response register.
// Depends on clle_pkg; drives clle_datapath through ctl_t.
`timescale 1ns / 1ps

module clle_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [clle_pkg::CMD_W-1:0]  req_command,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [clle_pkg::STAT_W-1:0] rsp_status,
	output logic [clle_pkg::SLOT_W-1:0] rsp_slot,
	output clle_pkg::ctl_t              ctl,
	input  clle_pkg::sts_t              sts
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_START   = 3'd1;
	localparam logic [2:0] S_WALK    = 3'd2;
	localparam logic [2:0] S_LINK    = 3'd3;
	localparam logic [2:0] S_SETLINK = 3'd4;
	localparam logic [2:0] S_FREE    = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0]          state_q, state_d;
	clle_pkg::cmd_t      cmd_q;
	clle_pkg::stat_t     status_q, status_d;
	logic                out_valid_q;
	clle_pkg::stat_t     out_status_q;
	logic [clle_pkg::SLOT_W-1:0] out_slot_q;
	logic                accept;
	logic                out_load;

	assign req_ready  = state_q == S_IDLE;
	assign accept     = req_valid && req_ready;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || rsp_ready);
	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot   = out_slot_q;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		ctl      = '0;
		ctl.tail = cmd_q == clle_pkg::CMD_INS_TAIL;
		unique case (state_q)
			S_IDLE: begin
				ctl.capture = accept;
				if (accept) begin
					state_d = S_START;
				end
			end
			S_START: begin
				status_d = clle_pkg::ST_OK;
				state_d  = S_DONE;
				unique case (cmd_q) inside
					clle_pkg::CMD_INS_HEAD, clle_pkg::CMD_INS_TAIL, clle_pkg::CMD_INS_POS: begin
						if (sts.free_nil) begin
							status_d = clle_pkg::ST_NOSPACE;
						end else begin
							ctl.alloc     = 1'b1;
							ctl.init_walk = 1'b1;
							state_d       = S_WALK;
						end
					end
					clle_pkg::CMD_DEL_HEAD: begin
						if (sts.head_nil) begin
							status_d = clle_pkg::ST_EMPTY;
						end else begin
							ctl.pop_head = 1'b1;
						end
					end
					clle_pkg::CMD_DEL_VAL: begin
						if (sts.head_nil) begin
							status_d = clle_pkg::ST_EMPTY;
						end else begin
							ctl.init_walk = 1'b1;
							state_d       = S_WALK;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				unique case (cmd_q) inside
					clle_pkg::CMD_INS_HEAD: begin
						state_d = S_LINK;
					end
					clle_pkg::CMD_INS_TAIL: begin
						if (sts.cur_cell && sts.cnt_lt_cells) begin
							ctl.step = 1'b1;
						end else begin
							state_d = S_LINK;
						end
					end
					clle_pkg::CMD_INS_POS: begin
						if (sts.cur_cell && sts.cnt_lt_pos) begin
							ctl.step = 1'b1;
						end else if (sts.cnt_lt_pos) begin
							// give the taken cell back
							ctl.free_c = 1'b1;
							status_d   = clle_pkg::ST_RANGE;
							state_d    = S_DONE;
						end else begin
							state_d = S_LINK;
						end
					end
					clle_pkg::CMD_DEL_VAL: begin
						if (sts.cur_cell && sts.cnt_lt_cells && !sts.data_match) begin
							ctl.step = 1'b1;
						end else if (!sts.cur_cell || !sts.data_match) begin
							status_d = clle_pkg::ST_NOTFOUND;
							state_d  = S_DONE;
						end else begin
							ctl.unlink = 1'b1;
							state_d    = S_FREE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_LINK: begin
				ctl.write_c = 1'b1;
				state_d     = S_SETLINK;
			end
			S_SETLINK: begin
				ctl.link_c = 1'b1;
				state_d    = S_DONE;
			end
			S_FREE: begin
				ctl.free_cur = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req_command;
		end
		status_q <= status_d;
		if (out_load) begin
			out_status_q <= status_q;
			out_slot_q   <= (status_q == clle_pkg::ST_OK)
				? clle_pkg::SLOT_W'(sts.slot) : '0;
		end
	end

endmodule

@@ rtl/core/clle_checker.sv @@
// Port-level checks for the cursor linked list engine, bound to the top.
// Depends on clle_pkg and cursor_linked_list_engine.
`timescale 1ns / 1ps

module clle_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [clle_pkg::STAT_W-1:0] rsp_status,
	input logic [clle_pkg::SLOT_W-1:0] rsp_slot
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status <= clle_pkg::ST_NOTFOUND))
		else $error("response status code out of range");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != clle_pkg::ST_OK) |-> (rsp_slot == '0))
		else $error("failed request reports a nonzero slot");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second request taken while one is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot)))
		else $error("stalled response changed or dropped");

endmodule

bind cursor_linked_list_engine clle_checker u_clle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_slot   (rsp.slot)
);
